// ===== hdl/source_text_tokenizer_unit_defines.svh =====
// assertion macros shared by the tokenizer rtl
// no dependencies; modules using these must have clock and reset signals
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define STT_ASSERT_SAME_CYCLE(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define STT_ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/stt_pkg.sv =====
// types, constants and helper functions for the source text tokenizer
// no dependencies
`timescale 1ns / 1ps

package stt_pkg;

   localparam int POS_WIDTH       = 16;
   localparam int KEYWORD_MAX_LEN = 6;
   localparam int BYTE_W          = 8;
   localparam int KIND_W          = 5;
   localparam int FIELD_W         = 16;
   localparam int BUF_IDX_W       = $clog2(KEYWORD_MAX_LEN);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_KEYWORD = 5'd0;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd2;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd3;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd4;
   localparam logic [KIND_W-1:0] KIND_STAR    = 5'd5;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd6;
   localparam logic [KIND_W-1:0] KIND_LT      = 5'd7;
   localparam logic [KIND_W-1:0] KIND_GT      = 5'd8;
   localparam logic [KIND_W-1:0] KIND_LE      = 5'd9;
   localparam logic [KIND_W-1:0] KIND_GE      = 5'd10;
   localparam logic [KIND_W-1:0] KIND_EQ_EQ   = 5'd11;
   localparam logic [KIND_W-1:0] KIND_NE      = 5'd12;
   localparam logic [KIND_W-1:0] KIND_NOT     = 5'd13;
   localparam logic [KIND_W-1:0] KIND_AND_AND = 5'd14;
   localparam logic [KIND_W-1:0] KIND_OR_OR   = 5'd15;
   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd16;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd17;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd18;
   localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd19;
   localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd20;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd21;
   localparam logic [KIND_W-1:0] KIND_NEWLINE = 5'd22;
   localparam logic [KIND_W-1:0] KIND_STRING  = 5'd23;
   localparam logic [KIND_W-1:0] KIND_EOF     = 5'd24;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd25;
   localparam logic [KIND_W-1:0] KIND_CHAR    = 5'd26;

   // characters with a role of their own
   localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LOWER_N   = 8'h6E;

   // keyword table
   localparam int KW_COUNT    = 7;
   localparam int KW_TEXT_MAX = 6;
   localparam logic [BYTE_W-1:0] KW_TEXT [KW_COUNT][KW_TEXT_MAX] = '{
      '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"u", "s", "e", 8'h00, 8'h00, 8'h00},
      '{"n", "o", "t", 8'h00, 8'h00, 8'h00},
      '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
      '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam int KW_LEN [KW_COUNT] = '{3, 2, 6, 3, 3, 3, 2};

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_EQ,
      MODE_GT,
      MODE_LT,
      MODE_BANG,
      MODE_AMP,
      MODE_BAR,
      MODE_STRING,
      MODE_ESCAPE
   } lex_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [FIELD_W-1:0] token_start;
      logic [FIELD_W-1:0] token_length;
      logic [BYTE_W-1:0]  string_char;
   } result_type;

   // up to two results caused by one byte: a from the pending token, b from the byte itself
   typedef struct packed {
      logic       a_valid;
      result_type a;
      logic       b_valid;
      result_type b;
   } record_type;

   typedef struct packed {
      logic              is_eof;
      logic              has_single;
      logic [KIND_W-1:0] single_kind;
      logic              opens;
      lex_mode_type      next_mode;
   } start_info_type;

   function automatic logic is_word_head(input logic [BYTE_W-1:0] c);
      return c inside {["a":"z"], ["A":"Z"], "_"};
   endfunction

   function automatic logic is_decimal(input logic [BYTE_W-1:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic result_type make_result(input logic [KIND_W-1:0]    kind,
                                              input logic [POS_WIDTH-1:0] start,
                                              input logic [POS_WIDTH-1:0] len,
                                              input logic [BYTE_W-1:0]    ch);
      result_type r;
      r.token_kind   = kind;
      r.token_start  = FIELD_W'(start);
      r.token_length = FIELD_W'(len);
      r.string_char  = ch;
      return r;
   endfunction

   // how a byte is lexed from the idle mode
   function automatic start_info_type start_lookup(input logic [BYTE_W-1:0] c);
      start_info_type s;
      s = '{is_eof: 1'b0, has_single: 1'b0, single_kind: KIND_UNKNOWN,
            opens: 1'b0, next_mode: MODE_IDLE};
      case (c)
         CH_SPACE, CH_TAB, CH_CR: begin
         end
         CH_NUL:     s.is_eof = 1'b1;
         "+":        begin s.has_single = 1'b1; s.single_kind = KIND_PLUS;    end
         "-":        begin s.has_single = 1'b1; s.single_kind = KIND_MINUS;   end
         "*":        begin s.has_single = 1'b1; s.single_kind = KIND_STAR;    end
         "/":        begin s.has_single = 1'b1; s.single_kind = KIND_SLASH;   end
         ",":        begin s.has_single = 1'b1; s.single_kind = KIND_COMMA;   end
         CH_NEWLINE: begin s.has_single = 1'b1; s.single_kind = KIND_NEWLINE; end
         "(":        begin s.has_single = 1'b1; s.single_kind = KIND_LPAREN;  end
         ")":        begin s.has_single = 1'b1; s.single_kind = KIND_RPAREN;  end
         "{":        begin s.has_single = 1'b1; s.single_kind = KIND_LBRACE;  end
         "}":        begin s.has_single = 1'b1; s.single_kind = KIND_RBRACE;  end
         "=":        begin s.opens = 1'b1; s.next_mode = MODE_EQ;     end
         ">":        begin s.opens = 1'b1; s.next_mode = MODE_GT;     end
         "<":        begin s.opens = 1'b1; s.next_mode = MODE_LT;     end
         "!":        begin s.opens = 1'b1; s.next_mode = MODE_BANG;   end
         "&":        begin s.opens = 1'b1; s.next_mode = MODE_AMP;    end
         "|":        begin s.opens = 1'b1; s.next_mode = MODE_BAR;    end
         CH_QUOTE:   begin s.opens = 1'b1; s.next_mode = MODE_STRING; end
         default: begin
            if (is_word_head(c)) begin
               s.opens     = 1'b1;
               s.next_mode = MODE_IDENT;
            end else if (is_decimal(c)) begin
               s.opens     = 1'b1;
               s.next_mode = MODE_NUMBER;
            end else begin
               s.has_single  = 1'b1;
               s.single_kind = KIND_UNKNOWN;
            end
         end
      endcase
      return s;
   endfunction

   // pending operator modes: second byte, pair kind, lone kind
   function automatic logic [BYTE_W-1:0] op_second(input lex_mode_type m);
      case (m)
         MODE_AMP: return "&";
         MODE_BAR: return "|";
         default:  return "=";
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] op_pair(input lex_mode_type m);
      case (m)
         MODE_EQ:   return KIND_EQ_EQ;
         MODE_GT:   return KIND_GE;
         MODE_LT:   return KIND_LE;
         MODE_BANG: return KIND_NE;
         MODE_AMP:  return KIND_AND_AND;
         MODE_BAR:  return KIND_OR_OR;
         default:   return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] op_lone(input lex_mode_type m);
      case (m)
         MODE_EQ:   return KIND_ASSIGN;
         MODE_GT:   return KIND_GT;
         MODE_LT:   return KIND_LT;
         MODE_BANG: return KIND_NOT;
         default:   return KIND_UNKNOWN;
      endcase
   endfunction

endpackage

// ===== hdl/stt_channels.sv =====
// valid/ready channel interfaces for the tokenizer byte input and result output
// depends on stt_pkg
`timescale 1ns / 1ps

interface stt_req_if import stt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [FIELD_W-1:0] token_start;
   logic [FIELD_W-1:0] token_length;
   logic [BYTE_W-1:0]  string_char;
   logic               last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output string_char, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input string_char, input last_of_run,
                   output ready);
endinterface

// ===== hdl/stt_lex.sv =====
// front end: accepts source bytes, runs the lexer modes and builds result records
// depends on stt_pkg, stt_channels and the shared assertion macros
`timescale 1ns / 1ps
`include "source_text_tokenizer_unit_defines.svh"

module stt_lex import stt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req,
   input  logic       queue_full,
   output logic       push,
   output record_type push_rec
);

   lex_mode_type         mode_ff, mode_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [POS_WIDTH-1:0] pstart_ff, pstart_in;
   logic [POS_WIDTH-1:0] plen_ff, plen_in;
   logic [BYTE_W-1:0]    prefix_ff [KEYWORD_MAX_LEN];
   logic                 buf_wr;
   logic [BUF_IDX_W-1:0] buf_idx;
   logic [BYTE_W-1:0]    b;
   logic                 accept;
   logic                 b_alnum;
   logic                 b_digit;
   logic                 kw_hit;
   logic                 relex;
   logic                 end_text;
   start_info_type       st;
   record_type           rec;

   assign b         = req.text_byte;
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b_digit   = is_decimal(b);
   assign b_alnum   = is_word_head(b) || b_digit;
   assign st        = start_lookup(b);

   // keyword compare against the prefix buffer
   always_comb begin
      logic hit_one;
      kw_hit = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         hit_one = (plen_ff == POS_WIDTH'(KW_LEN[i]));
         for (int j = 0; j < KW_TEXT_MAX; j++) begin
            if (j < KW_LEN[i] && prefix_ff[j] != KW_TEXT[i][j]) begin
               hit_one = 1'b0;
            end
         end
         kw_hit = kw_hit | hit_one;
      end
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE:   mode_in = st.next_mode;
         MODE_IDENT:  mode_in = b_alnum ? MODE_IDENT : st.next_mode;
         MODE_NUMBER: mode_in = b_digit ? MODE_NUMBER : st.next_mode;
         MODE_EQ, MODE_GT, MODE_LT, MODE_BANG, MODE_AMP, MODE_BAR: begin
            mode_in = (b == op_second(mode_ff)) ? MODE_IDLE : st.next_mode;
         end
         MODE_STRING, MODE_ESCAPE: begin
            if (b == CH_NUL) begin
               mode_in = MODE_IDLE;
            end else if (mode_ff == MODE_ESCAPE) begin
               mode_in = MODE_STRING;
            end else if (b == CH_QUOTE) begin
               mode_in = MODE_IDLE;
            end else if (b == CH_BACKSLASH) begin
               mode_in = MODE_ESCAPE;
            end else begin
               mode_in = MODE_STRING;
            end
         end
         default: mode_in = st.next_mode;
      endcase
   end

   // results and pending token bookkeeping
   always_comb begin
      rec       = '0;
      relex     = 1'b0;
      end_text  = 1'b0;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      buf_wr    = 1'b0;
      buf_idx   = plen_ff[BUF_IDX_W-1:0];
      case (mode_ff)
         MODE_IDLE: relex = 1'b1;
         MODE_IDENT: begin
            if (b_alnum) begin
               buf_wr  = (plen_ff < POS_WIDTH'(KEYWORD_MAX_LEN));
               plen_in = sat_inc(plen_ff);
            end else begin
               rec.a_valid = 1'b1;
               rec.a = make_result(kw_hit ? KIND_KEYWORD : KIND_IDENT,
                                   pstart_ff, plen_ff, CH_NUL);
               relex = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (b_digit) begin
               plen_in = sat_inc(plen_ff);
            end else begin
               rec.a_valid = 1'b1;
               rec.a = make_result(KIND_NUMBER, pstart_ff, plen_ff, CH_NUL);
               relex = 1'b1;
            end
         end
         MODE_EQ, MODE_GT, MODE_LT, MODE_BANG, MODE_AMP, MODE_BAR: begin
            rec.a_valid = 1'b1;
            if (b == op_second(mode_ff)) begin
               rec.a = make_result(op_pair(mode_ff), pstart_ff, POS_WIDTH'(2), CH_NUL);
            end else begin
               rec.a = make_result(op_lone(mode_ff), pstart_ff, POS_WIDTH'(1), CH_NUL);
               relex = 1'b1;
            end
         end
         MODE_STRING, MODE_ESCAPE: begin
            if (b == CH_NUL) begin
               // unterminated string
               rec.a_valid = 1'b1;
               rec.a = make_result(KIND_UNKNOWN, pstart_ff,
                                   sat_inc(pos_ff) - pstart_ff, CH_NUL);
               rec.b_valid = 1'b1;
               rec.b = make_result(KIND_EOF, pos_ff, '0, CH_NUL);
               end_text = 1'b1;
            end else if (mode_ff == MODE_ESCAPE) begin
               plen_in = sat_inc(plen_ff);
               rec.a_valid = 1'b1;
               rec.a = make_result(KIND_CHAR, pstart_ff, plen_in,
                                   (b == CH_LOWER_N) ? CH_NEWLINE : b);
            end else if (b == CH_QUOTE) begin
               rec.a_valid = 1'b1;
               rec.a = make_result(KIND_STRING, pstart_ff, plen_ff, CH_NUL);
            end else if (b != CH_BACKSLASH) begin
               plen_in = sat_inc(plen_ff);
               rec.a_valid = 1'b1;
               rec.a = make_result(KIND_CHAR, pstart_ff, plen_in, b);
            end
         end
         default: relex = 1'b1;
      endcase

      if (relex) begin
         if (st.is_eof) begin
            rec.b_valid = 1'b1;
            rec.b = make_result(KIND_EOF, pos_ff, '0, CH_NUL);
            end_text = 1'b1;
         end else if (st.has_single) begin
            rec.b_valid = 1'b1;
            rec.b = make_result(st.single_kind, pos_ff, POS_WIDTH'(1), CH_NUL);
         end else if (st.opens) begin
            pstart_in = pos_ff;
            plen_in   = (st.next_mode == MODE_STRING) ? '0 : POS_WIDTH'(1);
            buf_wr    = (st.next_mode == MODE_IDENT);
            buf_idx   = '0;
         end
      end

      if (end_text) begin
         pos_in    = '0;
         pstart_in = '0;
         plen_in   = '0;
      end else begin
         pos_in = sat_inc(pos_ff);
      end
   end

   assign push     = accept && (rec.a_valid || rec.b_valid);
   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < KEYWORD_MAX_LEN; k++) begin
         if (accept && buf_wr && buf_idx == BUF_IDX_W'(k)) begin
            prefix_ff[k] <= b;
         end
      end
   end

   `STT_ASSERT_NEXT_CYCLE(a_eof_restarts,
      push && push_rec.b_valid && push_rec.b.token_kind == KIND_EOF,
      mode_ff == MODE_IDLE && pos_ff == '0 && plen_ff == '0,
      "end of text did not return the lexer to offset zero")

   `STT_ASSERT_SAME_CYCLE(a_two_only_on_flush,
      push && push_rec.a_valid && push_rec.b_valid,
      mode_ff != MODE_IDLE,
      "two results from a byte seen in idle mode")

endmodule

// ===== hdl/stt_queue.sv =====
// short record queue between the lexer front end and the result back end
// depends on stt_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "source_text_tokenizer_unit_defines.svh"

module stt_queue import stt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  record_type push_rec,
   output logic       full,
   output logic       head_valid,
   output record_type head_rec,
   input  logic       pop
);

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   record_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_rec;
      end
   end

   `STT_ASSERT_SAME_CYCLE(a_no_push_when_full, push, !full,
      "record written into a full queue")

   `STT_ASSERT_SAME_CYCLE(a_no_pop_when_empty, pop, count_ff != '0,
      "record taken from an empty queue")

endmodule

// ===== hdl/stt_emit.sv =====
// back end: holds one record in an output register and sends its results in order
// depends on stt_pkg, stt_channels and the shared assertion macros
`timescale 1ns / 1ps
`include "source_text_tokenizer_unit_defines.svh"

module stt_emit import stt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  record_type head_rec,
   output logic       pop,
   stt_rsp_if.source  rsp
);

   record_type cur_ff, cur_in;
   logic       fire;
   logic       cur_last;
   logic       cur_any;
   result_type shown;

   assign cur_any  = cur_ff.a_valid || cur_ff.b_valid;
   assign cur_last = !(cur_ff.a_valid && cur_ff.b_valid);
   assign fire     = rsp.valid && rsp.ready;
   assign pop      = head_valid && (!cur_any || (fire && cur_last));
   assign shown    = cur_ff.a_valid ? cur_ff.a : cur_ff.b;

   assign rsp.valid        = cur_any;
   assign rsp.token_kind   = shown.token_kind;
   assign rsp.token_start  = shown.token_start;
   assign rsp.token_length = shown.token_length;
   assign rsp.string_char  = shown.string_char;
   assign rsp.last_of_run  = cur_last;

   always_comb begin
      cur_in = cur_ff;
      if (pop) begin
         cur_in = head_rec;
      end else if (fire) begin
         if (cur_ff.a_valid) begin
            cur_in.a_valid = 1'b0;
         end else begin
            cur_in.b_valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.a_valid <= 1'b0;
         cur_ff.b_valid <= 1'b0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   `STT_ASSERT_NEXT_CYCLE(a_second_follows,
      fire && cur_ff.a_valid && cur_ff.b_valid,
      rsp.valid && !rsp.last_of_run == 1'b0 && rsp.token_kind == $past(cur_ff.b.token_kind),
      "second result of a byte lost after the first transfer")

endmodule

// ===== hdl/source_text_tokenizer_unit.sv =====
// channel   | dir | payload
// req_bus   | in  | text_byte
// rsp_bus   | out | token_kind, token_start, token_length, string_char, last_of_run
//
// one source byte per cycle unless the queue is full; up to two results per byte,
// sent one per cycle while rsp_bus is ready; the lexer front end finishes a byte
// in the cycle it is taken; a four-record queue and the output register part the
// front end from the result side; req_bus stalls only when that queue is full
// no clearing pass after reset; top level of the source text tokenizer; depends on
// stt_pkg, stt_channels, stt_lex, stt_queue and stt_emit
`timescale 1ns / 1ps

module source_text_tokenizer_unit import stt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_bus,
   stt_rsp_if.source rsp_bus
);

   logic       push;
   record_type push_rec;
   logic       queue_full;
   logic       head_valid;
   record_type head_rec;
   logic       pop;

   stt_lex u_lex (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop)
   );

   stt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

// ===== test/tb_source_text_tokenizer_unit.sv =====
// self-checking testbench for source_text_tokenizer_unit: byte stream in, token stream out
// depends on stt_pkg, stt_channels and the tokenizer rtl
// a startup table, then random source texts under several flow-control mixes
`timescale 1ns / 1ps

module tb_source_text_tokenizer_unit;
   import stt_pkg::*;

   typedef enum int {
      PH_DIRECTED,
      PH_STEADY,
      PH_SENDER_GAPS,
      PH_SINK_STALLS,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } run_phase_type;

   typedef struct packed {
      result_type tok;
      logic       last;
   } token_due_type;

   // n_typed of zero means the token model supplies the expected results
   typedef struct packed {
      logic [BYTE_W-1:0] text;
      logic [1:0]        n_typed;
      result_type        t0;
      result_type        t1;
   } lex_case_type;

   localparam result_type NO_TOK = '0;
   localparam int STARTUP_COUNT = 24;
   localparam int ITEMS_PER_PHASE = 280;

   localparam lex_case_type STARTUP_CASES [STARTUP_COUNT] = '{
      '{"+",          2'd1, '{KIND_PLUS,     16'd0,  16'd1, 8'd0},       NO_TOK},
      '{8'hFF,        2'd1, '{KIND_UNKNOWN,  16'd1,  16'd1, 8'd0},       NO_TOK},
      '{"=",          2'd0, NO_TOK, NO_TOK},
      '{"=",          2'd1, '{KIND_EQ_EQ,    16'd2,  16'd2, 8'd0},       NO_TOK},
      '{"&",          2'd0, NO_TOK, NO_TOK},
      '{CH_SPACE,     2'd1, '{KIND_UNKNOWN,  16'd4,  16'd1, 8'd0},       NO_TOK},
      '{CH_QUOTE,     2'd0, NO_TOK, NO_TOK},
      '{CH_BACKSLASH, 2'd0, NO_TOK, NO_TOK},
      '{"n",          2'd1, '{KIND_CHAR,     16'd6,  16'd1, CH_NEWLINE}, NO_TOK},
      '{CH_BACKSLASH, 2'd0, NO_TOK, NO_TOK},
      '{"q",          2'd0, NO_TOK, NO_TOK},
      '{CH_QUOTE,     2'd1, '{KIND_STRING,   16'd6,  16'd2, 8'd0},       NO_TOK},
      '{"i",          2'd0, NO_TOK, NO_TOK},
      '{"f",          2'd0, NO_TOK, NO_TOK},
      '{"(",          2'd2, '{KIND_KEYWORD,  16'd12, 16'd2, 8'd0},
                            '{KIND_LPAREN,   16'd14, 16'd1, 8'd0}},
      '{CH_QUOTE,     2'd0, NO_TOK, NO_TOK},
      '{CH_BACKSLASH, 2'd0, NO_TOK, NO_TOK},
      '{CH_NUL,       2'd2, '{KIND_UNKNOWN,  16'd15, 16'd3, 8'd0},
                            '{KIND_EOF,      16'd17, 16'd0, 8'd0}},
      '{CH_NUL,       2'd1, '{KIND_EOF,      16'd0,  16'd0, 8'd0},       NO_TOK},
      '{"7",          2'd0, NO_TOK, NO_TOK},
      '{"<",          2'd1, '{KIND_NUMBER,   16'd0,  16'd1, 8'd0},       NO_TOK},
      '{"=",          2'd1, '{KIND_LE,       16'd1,  16'd2, 8'd0},       NO_TOK},
      '{"|",          2'd0, NO_TOK, NO_TOK},
      '{CH_NUL,       2'd2, '{KIND_UNKNOWN,  16'd3,  16'd1, 8'd0},
                            '{KIND_EOF,      16'd4,  16'd0, 8'd0}}
   };

   logic clock;
   logic reset;

   stt_req_if req_bus ();
   stt_rsp_if rsp_bus ();

   source_text_tokenizer_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   string kw_words [7] = '{"let", "if", "return", "use", "not", "and", "or"};

   token_due_type     tokens_due [$];
   logic [BYTE_W-1:0] text_bytes [$];

   lex_mode_type         lx_mode;
   logic [POS_WIDTH-1:0] lx_pos;
   logic [POS_WIDTH-1:0] lx_start;
   logic [POS_WIDTH-1:0] lx_len;
   logic [BYTE_W-1:0]    lx_prefix [KEYWORD_MAX_LEN];

   run_phase_type phase = PH_DIRECTED;
   int send_gap_pct = 0;
   int sink_stall_pct = 0;
   int mismatch_count = 0;
   int results_checked = 0;
   int lexed_items = 0;
   int texts_made = 0;
   logic [31:0] kinds_seen = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", tokens_due.size());
      $display("[source_text_tokenizer_unit] ERROR");
      $finish;
   end

   function automatic logic [POS_WIDTH-1:0] bump(input logic [POS_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_letter(input logic [BYTE_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_numeral(input logic [BYTE_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // advances the token model by one byte and returns the results it causes
   function automatic int lex_byte(input logic [BYTE_W-1:0] b, output result_type [1:0] toks);
      int n;
      logic relex, eof, hit, same;
      logic [KIND_W-1:0] single, pair, lone;
      logic [BYTE_W-1:0] second;
      logic [POS_WIDTH-1:0] pos;
      n = 0;
      relex = 1'b0;
      eof = 1'b0;
      pos = lx_pos;
      toks = '0;
      case (lx_mode)
         MODE_IDENT: begin
            if (is_letter(b) || is_numeral(b)) begin
               if (lx_len < KEYWORD_MAX_LEN) lx_prefix[lx_len] = b;
               lx_len = bump(lx_len);
            end else begin
               hit = 1'b0;
               for (int w = 0; w < 7; w++) begin
                  if (lx_len == kw_words[w].len()) begin
                     same = 1'b1;
                     for (int j = 0; j < kw_words[w].len(); j++)
                        if (lx_prefix[j] != kw_words[w][j]) same = 1'b0;
                     hit |= same;
                  end
               end
               toks[0] = '{hit ? KIND_KEYWORD : KIND_IDENT, lx_start, lx_len, 8'd0};
               n = 1;
               relex = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_numeral(b)) begin
               lx_len = bump(lx_len);
            end else begin
               toks[0] = '{KIND_NUMBER, lx_start, lx_len, 8'd0};
               n = 1;
               relex = 1'b1;
            end
         end
         MODE_EQ, MODE_GT, MODE_LT, MODE_BANG, MODE_AMP, MODE_BAR: begin
            case (lx_mode)
               MODE_AMP: begin second = "&"; pair = KIND_AND_AND; lone = KIND_UNKNOWN; end
               MODE_BAR: begin second = "|"; pair = KIND_OR_OR;   lone = KIND_UNKNOWN; end
               MODE_EQ:  begin second = "="; pair = KIND_EQ_EQ;   lone = KIND_ASSIGN;  end
               MODE_GT:  begin second = "="; pair = KIND_GE;      lone = KIND_GT;      end
               MODE_LT:  begin second = "="; pair = KIND_LE;      lone = KIND_LT;      end
               default:  begin second = "="; pair = KIND_NE;      lone = KIND_NOT;     end
            endcase
            n = 1;
            if (b == second) begin
               toks[0] = '{pair, lx_start, 16'd2, 8'd0};
               lx_mode = MODE_IDLE;
            end else begin
               toks[0] = '{lone, lx_start, 16'd1, 8'd0};
               relex = 1'b1;
            end
         end
         MODE_STRING, MODE_ESCAPE: begin
            if (b == CH_NUL) begin
               toks[0] = '{KIND_UNKNOWN, lx_start, bump(pos) - lx_start, 8'd0};
               toks[1] = '{KIND_EOF, pos, 16'd0, 8'd0};
               n = 2;
               eof = 1'b1;
            end else if (lx_mode == MODE_ESCAPE) begin
               lx_len = bump(lx_len);
               toks[0] = '{KIND_CHAR, lx_start, lx_len, (b == CH_LOWER_N) ? CH_NEWLINE : b};
               n = 1;
               lx_mode = MODE_STRING;
            end else if (b == CH_QUOTE) begin
               toks[0] = '{KIND_STRING, lx_start, lx_len, 8'd0};
               n = 1;
               lx_mode = MODE_IDLE;
            end else if (b == CH_BACKSLASH) begin
               lx_mode = MODE_ESCAPE;
            end else begin
               lx_len = bump(lx_len);
               toks[0] = '{KIND_CHAR, lx_start, lx_len, b};
               n = 1;
            end
         end
         default: relex = 1'b1;
      endcase

      if (relex) begin
         lx_mode = MODE_IDLE;
         // keyword kind never comes from a single byte, so it marks none here
         single = KIND_KEYWORD;
         case (b)
            CH_SPACE, CH_TAB, CH_CR: begin
            end
            CH_NUL: begin
               toks[n] = '{KIND_EOF, pos, 16'd0, 8'd0};
               n++;
               eof = 1'b1;
            end
            "+":        single = KIND_PLUS;
            "-":        single = KIND_MINUS;
            "*":        single = KIND_STAR;
            "/":        single = KIND_SLASH;
            ",":        single = KIND_COMMA;
            CH_NEWLINE: single = KIND_NEWLINE;
            "(":        single = KIND_LPAREN;
            ")":        single = KIND_RPAREN;
            "{":        single = KIND_LBRACE;
            "}":        single = KIND_RBRACE;
            "=":        lx_mode = MODE_EQ;
            ">":        lx_mode = MODE_GT;
            "<":        lx_mode = MODE_LT;
            "!":        lx_mode = MODE_BANG;
            "&":        lx_mode = MODE_AMP;
            "|":        lx_mode = MODE_BAR;
            CH_QUOTE:   lx_mode = MODE_STRING;
            default: begin
               if (is_letter(b)) begin
                  lx_mode = MODE_IDENT;
                  lx_prefix[0] = b;
               end else if (is_numeral(b)) begin
                  lx_mode = MODE_NUMBER;
               end else begin
                  single = KIND_UNKNOWN;
               end
            end
         endcase
         if (single != KIND_KEYWORD) begin
            toks[n] = '{single, pos, 16'd1, 8'd0};
            n++;
         end else if (lx_mode != MODE_IDLE) begin
            lx_start = pos;
            lx_len = (lx_mode == MODE_STRING) ? '0 : 16'd1;
         end
      end

      if (eof) begin
         lx_mode = MODE_IDLE;
         lx_pos = '0;
         lx_start = '0;
         lx_len = '0;
      end else begin
         lx_pos = bump(pos);
      end
      return n;
   endfunction

   task automatic report_error(input string msg);
      if (mismatch_count < 40) $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [BYTE_W-1:0] pick_alnum();
      if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
      return pick_letter();
   endfunction

   function automatic logic [BYTE_W-1:0] pick_string_byte();
      logic [BYTE_W-1:0] c;
      if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_QUOTE || c == CH_BACKSLASH) c = "x";
      return c;
   endfunction

   // string contents with plain bytes and escapes, no closing quote
   task automatic push_string_body();
      int count;
      count = $urandom_range(0, 6);
      text_bytes.push_back(CH_QUOTE);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            text_bytes.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 3))
               0: text_bytes.push_back(CH_LOWER_N);
               1: text_bytes.push_back(CH_BACKSLASH);
               2: text_bytes.push_back(CH_QUOTE);
               default: text_bytes.push_back(pick_string_byte());
            endcase
         end else begin
            text_bytes.push_back(pick_string_byte());
         end
      end
   endtask

   // one source text: mostly well-formed tokens, some noise, ending in nul
   task automatic compose_text();
      int n_tok, len;
      string word, ops, singles;
      logic [BYTE_W-1:0] c;
      ops = "=<>!&|";
      singles = "+-*/,(){}";
      n_tok = $urandom_range(2, 14);
      for (int t = 0; t < n_tok; t++) begin
         case ($urandom_range(0, 11))
            0: begin
               word = kw_words[$urandom_range(0, 6)];
               for (int j = 0; j < word.len(); j++) text_bytes.push_back(word[j]);
            end
            1: begin
               text_bytes.push_back(pick_letter());
               len = $urandom_range(0, 8);
               for (int j = 0; j < len; j++) text_bytes.push_back(pick_alnum());
            end
            2: begin
               word = kw_words[$urandom_range(0, 6)];
               if ($urandom_range(0, 1) == 0) word = {word, string'(pick_alnum())};
               else word = word.substr(0, word.len() - 2);
               for (int j = 0; j < word.len(); j++) text_bytes.push_back(word[j]);
            end
            3: begin
               len = $urandom_range(1, 5);
               for (int j = 0; j < len; j++) text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            end
            4: begin
               if ($urandom_range(0, 9) == 0) text_bytes.push_back(CH_NEWLINE);
               else text_bytes.push_back(singles[$urandom_range(0, singles.len() - 1)]);
            end
            5, 6: begin
               c = ops[$urandom_range(0, ops.len() - 1)];
               text_bytes.push_back(c);
               if ($urandom_range(0, 1) == 0) text_bytes.push_back((c == "&" || c == "|") ? c : "=");
            end
            7, 8: begin
               push_string_body();
               text_bytes.push_back(CH_QUOTE);
            end
            9:  text_bytes.push_back(8'($urandom_range(1, 255)));
            10: text_bytes.push_back(8'($urandom_range(128, 255)));
            default: begin
               len = $urandom_range(1, 3);
               for (int j = 0; j < len; j++) text_bytes.push_back(CH_SPACE);
            end
         endcase
         case ($urandom_range(0, 5))
            0, 1: begin
            end
            2: text_bytes.push_back(CH_TAB);
            3: text_bytes.push_back(CH_CR);
            4: text_bytes.push_back(CH_NEWLINE);
            default: text_bytes.push_back(CH_SPACE);
         endcase
      end
      case ($urandom_range(0, 9))
         0: push_string_body();
         1: begin
            push_string_body();
            text_bytes.push_back(CH_BACKSLASH);
         end
         default: begin
         end
      endcase
      text_bytes.push_back(CH_NUL);
      texts_made++;
   endtask

   task automatic feed_byte(input lex_case_type row);
      result_type [1:0] toks;
      int n;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= row.text;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n = lex_byte(row.text, toks);
      if (row.n_typed != 0) begin
         n = row.n_typed;
         toks[0] = row.t0;
         toks[1] = row.t1;
      end
      for (int i = 0; i < n; i++) tokens_due.push_back('{toks[i], logic'(i == n - 1)});
      lexed_items++;
   endtask

   task automatic feed_text();
      while (text_bytes.size() != 0) feed_byte('{text_bytes.pop_front(), 2'd0, NO_TOK, NO_TOK});
   endtask

   // result side: random stalls plus one long hold-off in the backpressure phase
   initial begin
      int hold;
      bit held_once;
      hold = 0;
      held_once = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_BACKPRESSURE && !held_once) begin
            hold = 300;
            held_once = 1'b1;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      token_due_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         kinds_seen[rsp_bus.token_kind] = 1'b1;
         if (tokens_due.size() == 0) begin
            report_error($sformatf("result kind %0d start %0d with nothing expected",
                                   rsp_bus.token_kind, rsp_bus.token_start));
         end else begin
            want = tokens_due.pop_front();
            if (rsp_bus.token_kind !== want.tok.token_kind)
               report_error($sformatf("kind %0d, expected %0d (start %0d)", rsp_bus.token_kind,
                                      want.tok.token_kind, want.tok.token_start));
            if (rsp_bus.token_start !== want.tok.token_start)
               report_error($sformatf("start %0d, expected %0d (kind %0d)", rsp_bus.token_start,
                                      want.tok.token_start, want.tok.token_kind));
            if (rsp_bus.token_length !== want.tok.token_length)
               report_error($sformatf("length %0d, expected %0d (kind %0d start %0d)",
                                      rsp_bus.token_length, want.tok.token_length,
                                      want.tok.token_kind, want.tok.token_start));
            if (rsp_bus.string_char !== want.tok.string_char)
               report_error($sformatf("char %02h, expected %02h (start %0d)", rsp_bus.string_char,
                                      want.tok.string_char, want.tok.token_start));
            if (rsp_bus.last_of_run !== want.last)
               report_error($sformatf("last flag %b, expected %b (kind %0d start %0d)",
                                      rsp_bus.last_of_run, want.last, want.tok.token_kind,
                                      want.tok.token_start));
         end
      end
   end

   initial begin
      int goal;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.text_byte <= CH_NUL;
      lx_mode = MODE_IDLE;
      lx_pos = '0;
      lx_start = '0;
      lx_len = '0;
      foreach (lx_prefix[i]) lx_prefix[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < STARTUP_COUNT; i++) feed_byte(STARTUP_CASES[i]);

      for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while (tokens_due.size() != 0) @(posedge clock);
         phase = run_phase_type'(p);
         case (phase)
            PH_SENDER_GAPS: begin send_gap_pct = 49; sink_stall_pct = 0;  end
            PH_SINK_STALLS: begin send_gap_pct = 0;  sink_stall_pct = 49; end
            PH_BOTH_IDLE:   begin send_gap_pct = 6;  sink_stall_pct = 6;  end
            default:        begin send_gap_pct = 0;  sink_stall_pct = 0;  end
         endcase
         goal = lexed_items + ITEMS_PER_PHASE;
         while (lexed_items < goal) begin
            compose_text();
            feed_text();
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d source bytes: a %0d-row startup table and %0d random texts",
               lexed_items, STARTUP_COUNT, texts_made);
      $display("%0d results checked, %0d of 27 token kinds seen, long result hold-off included",
               results_checked, $countones(kinds_seen));
      if (mismatch_count == 0) begin
         $display("[source_text_tokenizer_unit] OK");
      end else begin
         $display("[source_text_tokenizer_unit] ERROR");
      end
      $finish;
   end

endmodule
